@@ src/deq_pkg.sv @@
package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_QUERY      = 3'd4;
	localparam logic [2:0] CMD_LIST       = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] item;
		logic                     is_empty;
		logic                     last;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH_F,
		OP_PUSH_B,
		OP_POP_F,
		OP_POP_B,
		OP_LIST_FIRST,
		OP_LIST_NEXT
	} dp_op_t;

	typedef struct packed {
		logic       load_in;
		dp_op_t     op;
		logic       load_out;
		logic       out_from_mem;
		logic       out_list;
		logic [1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic       full;
		logic       empty;
		logic       list_last;
	} dp_sts_t;

endpackage

@@ src/double_ended_queue_core.sv @@
// Push, query and failed pop: S_EXEC registers the result beat, S_OUT presents it.
// Successful pop: S_EXEC issues the registered memory read, S_READ loads the result.
// List: S_EXEC reads the first entry, S_LREAD loads it and S_OUT presents it; each
// further stored entry is read from S_OUT, loaded in S_LREAD and presented again.
// One command in flight; the next beat is taken the cycle after the last result leaves.
// Reset empties the queue (front index and count to zero); entry memory is not cleared.
module double_ended_queue_core import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	deq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

@@ src/deq_datapath.sv @@
module deq_datapath import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output rsp_t    rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
	localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

	logic [2:0]        cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [IW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     idx_q;
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	rsp_t              rsp_q;

	logic [IW-1:0]     front_d;
	logic [CW-1:0]     count_d;
	logic [IW-1:0]     idx_d;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic              list_last;

	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
		input logic [IW-1:0] off);
		logic [IW:0] sum;
		sum = {1'b0, front} + {1'b0, off};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[IW-1:0];
	endfunction

	assign list_last = (CW'(idx_q) + CW'(1)) == count_q;

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		idx_d   = idx_q;
		wr_en   = 1'b0;
		wr_addr = front_q;
		rd_en   = 1'b0;
		rd_addr = front_q;
		case (cmd.op)
			OP_PUSH_F: begin
				front_d = (front_q == '0) ? LAST_SLOT : front_q - IW'(1);
				wr_en   = 1'b1;
				wr_addr = front_d;
				count_d = count_q + CW'(1);
			end
			OP_PUSH_B: begin
				wr_en   = 1'b1;
				wr_addr = slot_of(front_q, count_q[IW-1:0]);
				count_d = count_q + CW'(1);
			end
			OP_POP_F: begin
				rd_en   = 1'b1;
				front_d = (front_q == LAST_SLOT) ? '0 : front_q + IW'(1);
				count_d = count_q - CW'(1);
			end
			OP_POP_B: begin
				rd_en   = 1'b1;
				count_d = count_q - CW'(1);
				rd_addr = slot_of(front_q, count_d[IW-1:0]);
			end
			OP_LIST_FIRST: begin
				rd_en = 1'b1;
				idx_d = '0;
			end
			OP_LIST_NEXT: begin
				rd_en   = 1'b1;
				idx_d   = idx_q + IW'(1);
				rd_addr = slot_of(front_q, idx_d);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (cmd.load_in) begin
			cmd_q <= req.command;
			val_q <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= val_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.status   <= cmd.status;
			rsp_q.item     <= cmd.out_from_mem ? rd_q : '0;
			rsp_q.is_empty <= (count_d == '0);
			rsp_q.last     <= cmd.out_list ? list_last : 1'b1;
		end
	end

	assign sts.command   = cmd_q;
	assign sts.full      = (count_q >= DEPTH_C);
	assign sts.empty     = (count_q == '0);
	assign sts.list_last = list_last;
	assign rsp           = rsp_q;

endmodule

@@ src/deq_ctrl.sv @@
module deq_ctrl import deq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_LREAD,
		S_OUT
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   valid_q;
	logic   list_q;

	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		cmd.status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = req_valid;
			end
			S_EXEC: begin
				case (sts.command) inside
					CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
						cmd.load_out = 1'b1;
						if (sts.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.op = (sts.command == CMD_PUSH_FRONT) ? OP_PUSH_F : OP_PUSH_B;
						end
					end
					CMD_POP_FRONT, CMD_POP_BACK: begin
						if (sts.empty) begin
							cmd.load_out = 1'b1;
							cmd.status   = ST_EMPTY;
						end else begin
							cmd.op = (sts.command == CMD_POP_FRONT) ? OP_POP_F : OP_POP_B;
						end
					end
					CMD_LIST: begin
						if (sts.empty) begin
							cmd.load_out = 1'b1;
						end else begin
							cmd.op = OP_LIST_FIRST;
						end
					end
					default: begin
						cmd.load_out = 1'b1;
					end
				endcase
			end
			S_READ: begin
				cmd.load_out     = 1'b1;
				cmd.out_from_mem = 1'b1;
			end
			S_LREAD: begin
				cmd.load_out     = 1'b1;
				cmd.out_from_mem = 1'b1;
				cmd.out_list     = 1'b1;
			end
			S_OUT: begin
				if (!rsp_stall && list_q && !sts.list_last) begin
					cmd.op = OP_LIST_NEXT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
			valid_q <= 1'b0;
			list_q  <= 1'b0;
		end else begin
			unique case (state_q) inside
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
						stall_q <= 1'b1;
					end
				end
				S_EXEC: begin
					if (cmd.op == OP_POP_F || cmd.op == OP_POP_B) begin
						state_q <= S_READ;
					end else if (cmd.op == OP_LIST_FIRST) begin
						state_q <= S_LREAD;
						list_q  <= 1'b1;
					end else begin
						state_q <= S_OUT;
						valid_q <= 1'b1;
					end
				end
				S_READ, S_LREAD: begin
					state_q <= S_OUT;
					valid_q <= 1'b1;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						valid_q <= 1'b0;
						if (cmd.op == OP_LIST_NEXT) begin
							state_q <= S_LREAD;
						end else begin
							state_q <= S_IDLE;
							stall_q <= 1'b0;
							list_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = stall_q;
	assign rsp_valid = valid_q;

endmodule
